>>> rtl/core/lpa_pkg.sv
// shared types, constants and helpers for the looping playhead advance block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lpa_pkg;

    localparam int TIME_BITS_DEF = 64;
    localparam int DIV_W         = 96;
    localparam int STEP_W        = 7;
    localparam int CFG_IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PAUSED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_NUM   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_DEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_EN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END   = 3'd5;

    localparam logic [STEP_W-1:0] STEPS_SCALE = 7'd96;
    localparam logic [STEP_W-1:0] STEPS_WRAP  = 7'd66;

    typedef struct packed {
        logic        paused;
        logic [31:0] rate_num;
        logic [30:0] rate_den;
        logic        loop_en;
        logic [63:0] loop_start;
        logic [63:0] loop_end;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DIV_W-1:0]  dividend;
        logic [63:0]       divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [63:0]      rem;
    } t_div_rsp;

    // true when v is a signed value of tb bits
    function automatic logic fits(logic [63:0] v, int unsigned tb);
        logic [63:0] s;
        s = 64'($signed(v) >>> (tb - 1));
        return (s == 64'd0) || (s == {64{1'b1}});
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/lpa_cfg.sv
// configuration register file of the looping playhead advance block
// depends on lpa_pkg
`timescale 1ns / 1ps
`default_nettype none
module lpa_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [lpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]                   i_cfg_data,
    output lpa_pkg::t_cfg                      o_cfg
);

    lpa_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.paused     <= 1'b0;
            r_cfg.rate_num   <= 32'd1;
            r_cfg.rate_den   <= 31'd1;
            r_cfg.loop_en    <= 1'b0;
            r_cfg.loop_start <= 64'd0;
            r_cfg.loop_end   <= 64'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lpa_pkg::CFG_PAUSED:     r_cfg.paused     <= i_cfg_data[0];
                lpa_pkg::CFG_RATE_NUM:   r_cfg.rate_num   <= i_cfg_data[31:0];
                lpa_pkg::CFG_RATE_DEN:   r_cfg.rate_den   <= i_cfg_data[30:0];
                lpa_pkg::CFG_LOOP_EN:    r_cfg.loop_en    <= i_cfg_data[0];
                lpa_pkg::CFG_LOOP_START: r_cfg.loop_start <= i_cfg_data;
                lpa_pkg::CFG_LOOP_END:   r_cfg.loop_end   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

>>> rtl/core/lpa_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on lpa_pkg
`timescale 1ns / 1ps
`default_nettype none
module lpa_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lpa_pkg::t_div_req i_req,
    output lpa_pkg::t_div_rsp      o_rsp
);

    logic [lpa_pkg::DIV_W-1:0]  r_q;
    logic [63:0]                r_rem;
    logic [63:0]                r_d;
    logic [lpa_pkg::STEP_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [64:0]                sh;
    logic [64:0]                diff;
    logic                       ge;

    assign sh   = {r_rem, r_q[lpa_pkg::DIV_W-1]};
    assign diff = sh - {1'b0, r_d};
    assign ge   = (sh >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == lpa_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= 64'd0;
            r_d   <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[63:0] : sh[63:0];
            r_q   <= {r_q[lpa_pkg::DIV_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;

endmodule
`default_nettype wire

>>> rtl/core/looping_playhead_advance.sv
// Looping playhead advance: scales an elapsed duration by rate_num/rate_den
// (round half to even), adds it to the playhead and wraps into the loop window.
// Input channel: i_in_valid / o_in_stall with i_elapsed. A request is taken
// when valid is high and stall is low; stall stays high while a request is
// being worked on.
// Output channel: o_out_valid / i_out_stall with o_position and o_status
// (0 ok, 1 overflow or zero denominator, playhead left as it was). One result per request.
// Configuration: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index selects
// paused, rate_num, rate_den, loop_enable, loop_start, loop_end (0..5).
// The shared bit-serial divider runs 96 steps for the rate division and 66
// more for the window modulo, which is skipped without a loop window; both are
// skipped when paused or when the denominator is zero.
// One request at a time; the next is taken right after the result is parked
// in the output register, even while the receiver stalls it.
// Reset (synchronous, active low) clears the playhead to 0 and the
// registers to paused 0, rate 1/1, no loop.
`timescale 1ns / 1ps
`default_nettype none
module looping_playhead_advance #(
    parameter int TIME_BITS = lpa_pkg::TIME_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [63:0]                   i_elapsed,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [63:0]                        o_position,
    output logic                               o_status,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [lpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]                   i_cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL0 = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_D1GO = 4'd3;
    localparam logic [3:0] S_D1W  = 4'd4;
    localparam logic [3:0] S_RND  = 4'd5;
    localparam logic [3:0] S_ADD  = 4'd6;
    localparam logic [3:0] S_D2GO = 4'd7;
    localparam logic [3:0] S_D2W  = 4'd8;
    localparam logic [3:0] S_WRAP = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    localparam logic [63:0] T_HALF = 64'd1 << (TIME_BITS - 1);
    localparam logic [63:0] T_MAX  = T_HALF - 64'd1;

    lpa_pkg::t_cfg     cfg;
    lpa_pkg::t_div_req div_req;
    lpa_pkg::t_div_rsp div_rsp;

    logic [3:0]  r_state;
    logic [63:0] r_playhead;
    logic        r_status;
    logic [63:0] r_mag;
    logic [31:0] r_magn;
    logic        r_neg;
    logic [63:0] r_p0;
    logic [95:0] r_prod;
    logic [63:0] r_delta;
    logic [65:0] r_offmag;
    logic        r_offneg;
    logic [63:0] r_len;
    logic        r_ov;
    logic [63:0] r_pos;
    logic        r_st;

    logic        in_acc;
    logic        load_out;
    logic [31:0] mul_a;
    logic [63:0] mul_p;
    logic        rnd_up;
    logic [96:0] qr;
    logic        sc_fault;
    logic [64:0] adv;
    logic [65:0] off;
    logic        win;
    logic [63:0] m_adj;
    logic [63:0] wrapped;

    lpa_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lpa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign load_out    = (r_state == S_DONE) && (!r_ov || !i_out_stall);

    // one 32x32 multiplier shared by both halves of the elapsed magnitude
    assign mul_a = (r_state == S_MUL0) ? r_mag[31:0] : r_mag[63:32];
    assign mul_p = mul_a * r_magn;

    // rounding half to even, remainder is below the 31-bit denominator
    assign rnd_up = ({div_rsp.rem[30:0], 1'b0} > {1'b0, cfg.rate_den})
                 || (({div_rsp.rem[30:0], 1'b0} == {1'b0, cfg.rate_den})
                     && div_rsp.quot[0]);
    assign qr = {1'b0, div_rsp.quot} + {96'd0, rnd_up};
    assign sc_fault = (qr[96:64] != 33'd0)
                   || (r_neg ? (qr[63:0] > T_HALF) : (qr[63:0] > T_MAX));

    assign adv = {r_playhead[63], r_playhead} + {r_delta[63], r_delta};
    assign off = {adv[64], adv} - {{2{cfg.loop_start[63]}}, cfg.loop_start};
    assign win = cfg.loop_en && ($signed(cfg.loop_end) > $signed(cfg.loop_start));

    assign m_adj   = (r_offneg && div_rsp.rem != 64'd0) ? (r_len - div_rsp.rem)
                                                        : div_rsp.rem;
    assign wrapped = cfg.loop_start + m_adj;

    always_comb begin
        div_req.start    = 1'b0;
        div_req.steps    = lpa_pkg::STEPS_SCALE;
        div_req.dividend = r_prod;
        div_req.divisor  = {33'd0, cfg.rate_den};
        if (r_state == S_D1GO) begin
            div_req.start = 1'b1;
        end else if (r_state == S_D2GO) begin
            div_req.start    = 1'b1;
            div_req.steps    = lpa_pkg::STEPS_WRAP;
            div_req.dividend = {r_offmag, 30'd0};
            div_req.divisor  = r_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_playhead <= 64'd0;
            r_status   <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_status <= 1'b0;
                        if (cfg.paused) begin
                            r_state <= S_DONE;
                        end else if (cfg.rate_den == 31'd0) begin
                            r_status <= 1'b1;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_MUL0;
                        end
                    end
                end
                S_MUL0: r_state <= S_MUL1;
                S_MUL1: r_state <= S_D1GO;
                S_D1GO: r_state <= S_D1W;
                S_D1W: begin
                    if (div_rsp.done) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    if (sc_fault) begin
                        r_status <= 1'b1;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    if (win) begin
                        r_state <= S_D2GO;
                    end else begin
                        if (adv[64] == adv[63] && lpa_pkg::fits(adv[63:0], TIME_BITS)) begin
                            r_playhead <= adv[63:0];
                        end else begin
                            r_status <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_D2GO: r_state <= S_D2W;
                S_D2W: begin
                    if (div_rsp.done) begin
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    if (lpa_pkg::fits(wrapped, TIME_BITS)) begin
                        r_playhead <= wrapped;
                    end else begin
                        r_status <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mag  <= i_elapsed[63] ? (64'd0 - i_elapsed) : i_elapsed;
            r_magn <= cfg.rate_num[31] ? (32'd0 - cfg.rate_num) : cfg.rate_num;
            r_neg  <= i_elapsed[63] ^ cfg.rate_num[31];
        end
        if (r_state == S_MUL0) begin
            r_p0 <= mul_p;
        end
        if (r_state == S_MUL1) begin
            r_prod <= {32'd0, r_p0} + {mul_p, 32'd0};
        end
        if (r_state == S_RND) begin
            r_delta <= r_neg ? (64'd0 - qr[63:0]) : qr[63:0];
        end
        if (r_state == S_ADD) begin
            r_offneg <= off[65];
            r_offmag <= off[65] ? (66'd0 - off) : off;
            r_len    <= cfg.loop_end - cfg.loop_start;
        end
        if (load_out) begin
            r_pos <= r_playhead;
            r_st  <= r_status;
        end
    end

    assign o_out_valid = r_ov;
    assign o_position  = r_pos;
    assign o_status    = r_st;

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input taken while busy");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_D1W || r_state == S_D2W))
        else $error("divider finished outside a wait state");

    a_playhead_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_playhead))
            |-> ($past(r_state) == S_ADD || $past(r_state) == S_WRAP))
        else $error("playhead changed outside the update states");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (o_out_valid && r_state == S_IDLE))
        else $error("result not parked in output register");

endmodule
`default_nettype wire

>>> verif/lpa_checker.sv
// checker for the looping playhead advance block: tracks register writes,
// predicts position and status per request and compares results; uses lpa_pkg
`timescale 1ns / 1ps
module lpa_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [63:0]                   i_elapsed,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [63:0]                   i_position,
    input  logic                          i_status,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [lpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                   i_cfg_data,
    output int                            o_errors,
    output int                            o_pending
);

    typedef struct {
        logic [63:0] position;
        logic        status;
    } t_step_result;

    logic        cfg_paused;
    logic [31:0] cfg_num;
    logic [30:0] cfg_den;
    logic        cfg_loop_en;
    logic [63:0] cfg_start;
    logic [63:0] cfg_end;
    logic [63:0] model_playhead;
    t_step_result expected_steps[$];

    assign o_pending = expected_steps.size();

    function automatic logic signed [129:0] sext130(logic [63:0] v);
        return {{66{v[63]}}, v};
    endfunction

    // updates model_playhead and returns the predicted result
    function automatic t_step_result advance_playhead(logic [63:0] e);
        t_step_result res;
        logic [63:0] mag, delta;
        logic [32:0] magn;
        logic [127:0] prod, quo, rem;
        logic signed [129:0] adv, off, len, m;
        logic flip;
        res.status = 1'b0;
        if (!cfg_paused) begin
            if (cfg_den == 31'd0) begin
                res.status = 1'b1;
            end else begin
                mag  = e[63] ? -e : e;
                magn = cfg_num[31] ? (33'h1_0000_0000 - {1'b0, cfg_num}) : {1'b0, cfg_num};
                prod = 128'(mag) * 128'(magn);
                quo  = prod / 128'(cfg_den);
                rem  = prod % 128'(cfg_den);
                // round half to even
                if (2 * rem > 128'(cfg_den) || (2 * rem == 128'(cfg_den) && quo[0]))
                    quo = quo + 1;
                flip = e[63] ^ cfg_num[31];
                if (quo[127:64] != 0) begin
                    res.status = 1'b1;
                end else if (flip && quo > 128'h8000_0000_0000_0000) begin
                    res.status = 1'b1;
                end else if (!flip && quo > 128'h7FFF_FFFF_FFFF_FFFF) begin
                    res.status = 1'b1;
                end else begin
                    delta = flip ? -quo[63:0] : quo[63:0];
                    adv = sext130(model_playhead) + sext130(delta);
                    if (cfg_loop_en && $signed(cfg_end) > $signed(cfg_start)) begin
                        len = sext130(cfg_end) - sext130(cfg_start);
                        off = adv - sext130(cfg_start);
                        m = off % len;
                        if (m < 0)
                            m = m + len;
                        model_playhead = cfg_start + m[63:0];
                    end else if (adv >= sext130(64'h8000_0000_0000_0000)
                                 && adv <= sext130(64'h7FFF_FFFF_FFFF_FFFF)) begin
                        model_playhead = adv[63:0];
                    end else begin
                        res.status = 1'b1;
                    end
                end
            end
        end
        res.position = model_playhead;
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        t_step_result want;
        if (!i_rst_n) begin
            cfg_paused     <= 1'b0;
            cfg_num        <= 32'd1;
            cfg_den        <= 31'd1;
            cfg_loop_en    <= 1'b0;
            cfg_start      <= '0;
            cfg_end        <= '0;
            model_playhead = '0;
            o_errors       <= 0;
            expected_steps.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    lpa_pkg::CFG_PAUSED:     cfg_paused  <= i_cfg_data[0];
                    lpa_pkg::CFG_RATE_NUM:   cfg_num     <= i_cfg_data[31:0];
                    lpa_pkg::CFG_RATE_DEN:   cfg_den     <= i_cfg_data[30:0];
                    lpa_pkg::CFG_LOOP_EN:    cfg_loop_en <= i_cfg_data[0];
                    lpa_pkg::CFG_LOOP_START: cfg_start   <= i_cfg_data;
                    lpa_pkg::CFG_LOOP_END:   cfg_end     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_steps.push_back(advance_playhead(i_elapsed));
            if (i_out_valid && !i_out_stall) begin
                if (expected_steps.size() == 0) begin
                    $display("%0t: unexpected result pos %h status %b",
                             $time, i_position, i_status);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_steps.pop_front();
                    if (want.position !== i_position || want.status !== i_status) begin
                        $display("%0t: mismatch expected pos %h status %b, got pos %h status %b",
                                 $time, want.position, want.status, i_position, i_status);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

>>> verif/tb_looping_playhead_advance.sv
// testbench top for the looping playhead advance block: clock, reset, request
// stimulus, register writes and verdict; uses lpa_pkg and lpa_checker
`timescale 1ns / 1ps
module tb_looping_playhead_advance;

    localparam int WATCHDOG_LIMIT = 30000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [63:0]                   i_elapsed;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [63:0]                   o_position;
    logic                          o_status;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [lpa_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [63:0]                   i_cfg_data;

    int errors;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;
    int quiet_cycles;

    looping_playhead_advance dut (.*);

    lpa_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_elapsed(i_elapsed),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_position(o_position), .i_status(o_status),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stall, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_off)
            i_out_stall = 1'b1;
        else
            i_out_stall = ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_request(logic [63:0] e);
        int gap;
        i_in_valid = 1'b1;
        i_elapsed  = e;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            i_elapsed  = {$urandom, $urandom};
            gap = $urandom_range(6, 1);
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(logic [lpa_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [63:0] rand_elapsed();
        logic [63:0] v;
        int w;
        v = {$urandom, $urandom};
        if ($urandom_range(9) == 0)
            return v;
        w = $urandom_range(40, 1);
        v = v >> (64 - w);
        return ($urandom_range(1) != 0) ? -v : v;
    endfunction

    task automatic random_settings();
        logic [63:0] s;
        logic [63:0] len;
        case ($urandom_range(5))
            0: write_reg(lpa_pkg::CFG_RATE_NUM, 64'({$urandom}));
            1: write_reg(lpa_pkg::CFG_RATE_NUM, 64'($signed($urandom_range(8)) - 4));
            default: write_reg(lpa_pkg::CFG_RATE_NUM,
                               64'($signed($urandom_range(2000)) - 1000));
        endcase
        case ($urandom_range(3))
            0: write_reg(lpa_pkg::CFG_RATE_DEN, 64'h7FFF_FFFF);
            1: write_reg(lpa_pkg::CFG_RATE_DEN, 64'({$urandom}));
            default: write_reg(lpa_pkg::CFG_RATE_DEN, 64'($urandom_range(1000, 1)));
        endcase
        write_reg(lpa_pkg::CFG_PAUSED, 64'($urandom_range(7) == 0));
        write_reg(lpa_pkg::CFG_LOOP_EN, 64'($urandom_range(3) != 0));
        s   = {$urandom, $urandom} >> $urandom_range(63, 0);
        s   = ($urandom_range(1) != 0) ? -s : s;
        len = {$urandom, $urandom} >> $urandom_range(63, 2);
        if ($urandom_range(7) == 0)
            len = -len;
        write_reg(lpa_pkg::CFG_LOOP_START, s);
        write_reg(lpa_pkg::CFG_LOOP_END, s + len);
    endtask

    initial begin
        int phase;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_elapsed     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_out_stall   = 1'b0;
        hold_off      = 1'b0;
        quiet_cycles  = 0;
        send_idle_pct = 17;
        recv_idle_pct = 52;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset rate 1/1, no loop: extremes and unlooped overflow
        send_request(64'd1);
        send_request(64'h7FFF_FFFF_FFFF_FFFF);
        send_request(64'd1);
        send_request(64'h8000_0000_0000_0000);
        send_request(64'h8000_0000_0000_0000);
        send_request(64'hFFFF_FFFF_FFFF_FFFF);
        send_request(64'd0);
        // paused ignores everything
        write_reg(lpa_pkg::CFG_PAUSED, 64'd1);
        send_request(64'h7FFF_FFFF_FFFF_FFFF);
        write_reg(lpa_pkg::CFG_PAUSED, 64'd0);
        // half ties, extreme rate, scaled delta overflow
        write_reg(lpa_pkg::CFG_RATE_DEN, 64'd2);
        send_request(64'd1);
        send_request(64'd3);
        send_request(64'hFFFF_FFFF_FFFF_FFFD);
        write_reg(lpa_pkg::CFG_RATE_NUM, 64'hFFFF_FFFF_8000_0000);
        write_reg(lpa_pkg::CFG_RATE_DEN, 64'h7FFF_FFFF);
        send_request(64'h7FFF_FFFF_FFFF_FFFF);
        send_request(64'h8000_0000_0000_0000);
        write_reg(lpa_pkg::CFG_RATE_NUM, 64'h7FFF_FFFF);
        write_reg(lpa_pkg::CFG_RATE_DEN, 64'd1);
        send_request(64'h0000_0001_0000_0000);
        // zero denominator is a fault
        write_reg(lpa_pkg::CFG_RATE_DEN, 64'd0);
        send_request(64'd5);
        // loop window, wrapping both ways, then an empty window
        write_reg(lpa_pkg::CFG_RATE_NUM, 64'hFFFF_FFFF_FFFF_FFFD);
        write_reg(lpa_pkg::CFG_RATE_DEN, 64'd1);
        write_reg(lpa_pkg::CFG_LOOP_EN, 64'd1);
        write_reg(lpa_pkg::CFG_LOOP_START, 64'h8000_0000_0000_0000);
        write_reg(lpa_pkg::CFG_LOOP_END, 64'h7FFF_FFFF_FFFF_FFFF);
        send_request(64'h7FFF_FFFF_FFFF_FFFF);
        write_reg(lpa_pkg::CFG_LOOP_START, 64'hFFFF_FFFF_FFFF_FF9C);
        write_reg(lpa_pkg::CFG_LOOP_END, 64'd37);
        send_request(64'd1000);
        send_request(64'hFFFF_FFFF_FFFF_F000);
        write_reg(lpa_pkg::CFG_LOOP_END, 64'hFFFF_FFFF_FFFF_FF9C);
        send_request(64'd7);

        for (phase = 0; phase < 15; phase++) begin
            if (phase == 5) begin
                send_idle_pct = 52;
                recv_idle_pct = 17;
            end else if (phase == 10) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_settings();
            if (phase == 7) begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (1500) @(negedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            repeat (92) send_request(rand_elapsed());
        end

        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
